/* hdl/ptt_pkg.sv */
// Package for the priority task table: status and opcode codes, entry record,
// controller states and the priority encoder used on the per-priority lists.
// No dependencies.
`default_nettype none

package ptt_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int NUM_PRIO      = 16;

  localparam logic       OP_ADD = 1'b0;
  localparam logic       OP_RUN = 1'b1;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;

  localparam logic [3:0]  PRIO_RESET = 4'd9;
  localparam logic [31:0] RUNS_MAX   = 32'hFFFF_FFFF;

  localparam logic REG_MAX_PRIO = 1'b0;

  typedef struct packed {
    logic [3:0]  prio;
    logic [4:0]  id;
    logic [31:0] created;
    logic [31:0] ran_at;
    logic [31:0] runs;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT
  } state_t;

  function automatic logic [3:0] first_set(input logic [NUM_PRIO-1:0] mask);
    logic [3:0] idx;
    idx = '0;
    for (int i = NUM_PRIO - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* hdl/ptt_if.sv */
// Valid/ready channel interfaces for the priority task table: request
// channel and result channel. No dependencies.
`default_nettype none

interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  task_priority;
  logic [31:0] now_time;

  modport source (output valid, opcode, task_priority, now_time, input ready);
  modport sink   (input valid, opcode, task_priority, now_time, output ready);
  modport mon    (input valid, ready, opcode, task_priority, now_time);
endinterface

interface ptt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  task_id;
  logic [3:0]  out_priority;
  logic [31:0] runs_done;
  logic [31:0] created_time;
  logic        last_of_run;

  modport source (output valid, status, task_id, out_priority, runs_done,
                  created_time, last_of_run, input ready);
  modport sink   (input valid, status, task_id, out_priority, runs_done,
                  created_time, last_of_run, output ready);
  modport mon    (input valid, ready, status, task_id, out_priority, runs_done,
                  created_time, last_of_run);
endinterface

`default_nettype wire

/* hdl/priority_task_table.sv */
// Priority task table top level: entry memory, link memory, list heads/tails,
// run sequencer, result register and APB register port.
// Depends on ptt_pkg and ptt_if.
//
// Tasks live in an entry memory indexed by insertion slot; each of the 16
// priorities keeps a linked list (head/tail registers plus a next-link
// memory) so a run visits tasks by ascending priority, equal priorities in
// insertion order. An add, a rejected add or a run on an empty table loads its
// result straight into the output register. A run visits each task in two
// states: S_FETCH for the synchronous read of the entry and link memories, and
// S_EMIT, which holds while the output is full, to load the result and write
// back the run count and last-run time; the next read address is the link just
// read, or at a list's end the next priority's head. A result waits in the
// output register; a new request is taken while the last result of the
// previous one is being transferred. Nothing needs clearing after reset.
`default_nettype none

module priority_task_table #(
  parameter int TABLE_DEPTH = ptt_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  ptt_in_if.sink      task_in,
  ptt_out_if.source   task_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t          data_mem [TABLE_DEPTH];
  logic [IW-1:0]   next_mem [TABLE_DEPTH];
  entry_t          data_rdata;
  logic [IW-1:0]   next_rdata;

  state_t          state, state_next;
  logic [CW-1:0]   count;
  logic [IW-1:0]   head [NUM_PRIO];
  logic [IW-1:0]   tail [NUM_PRIO];
  logic [NUM_PRIO-1:0] nonempty;
  logic [3:0]      cur_prio;
  logic [IW-1:0]   cur_addr;
  logic [31:0]     now_r;
  logic [3:0]      max_priority;

  logic            out_valid;
  logic [2:0]      out_status, out_status_next;
  logic [4:0]      out_id, out_id_next;
  logic [3:0]      out_prio, out_prio_next;
  logic [31:0]     out_runs, out_runs_next;
  logic [31:0]     out_created, out_created_next;
  logic            out_last, out_last_next;
  logic            load_out;

  logic            data_we, next_we;
  logic [IW-1:0]   data_waddr, next_waddr, next_wdata;
  entry_t          data_wdata;

  logic            in_fire, out_free, emit_fire, is_full, is_bad, add_ok, run_start;
  logic            at_tail, has_higher, run_done;
  logic [3:0]      in_prio, first_prio, next_prio;
  logic [NUM_PRIO-1:0] higher;
  logic [31:0]     runs_inc;

  assign in_prio    = task_in.task_priority;
  assign out_free   = !out_valid || task_out.ready;
  assign task_in.ready = (state == S_IDLE) && out_free;
  assign in_fire    = task_in.valid && task_in.ready;
  assign is_full    = (count == CW'(TABLE_DEPTH));
  assign is_bad     = (in_prio > max_priority);
  assign add_ok     = in_fire && (task_in.opcode == OP_ADD) && !is_full && !is_bad;
  assign run_start  = in_fire && (task_in.opcode == OP_RUN) && (count != '0);
  assign first_prio = first_set(nonempty);
  assign higher     = nonempty & (16'hFFFE << cur_prio);
  assign has_higher = |higher;
  assign next_prio  = first_set(higher);
  assign at_tail    = (cur_addr == tail[cur_prio]);
  assign run_done   = at_tail && !has_higher;
  assign emit_fire  = (state == S_EMIT) && out_free;
  assign runs_inc   = (data_rdata.runs == RUNS_MAX) ? RUNS_MAX : data_rdata.runs + 32'd1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (run_start) state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = run_done ? S_IDLE : S_FETCH;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    load_out         = 1'b0;
    out_status_next  = ST_ADDED;
    out_id_next      = '0;
    out_prio_next    = '0;
    out_runs_next    = '0;
    out_created_next = '0;
    out_last_next    = 1'b1;
    data_we          = 1'b0;
    data_waddr       = cur_addr;
    data_wdata       = data_rdata;
    next_we          = 1'b0;
    next_waddr       = tail[in_prio];
    next_wdata       = IW'(count);
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (task_in.opcode == OP_ADD) begin
            load_out      = 1'b1;
            out_prio_next = in_prio;
            if (is_full) begin
              out_status_next = ST_FULL;
            end else if (is_bad) begin
              out_status_next = ST_BAD;
            end else begin
              out_status_next     = ST_ADDED;
              out_id_next         = 5'(count);
              out_created_next    = task_in.now_time;
              data_we             = 1'b1;
              data_waddr          = IW'(count);
              data_wdata.prio     = in_prio;
              data_wdata.id       = 5'(count);
              data_wdata.created  = task_in.now_time;
              data_wdata.ran_at   = '0;
              data_wdata.runs     = '0;
              next_we             = nonempty[in_prio];
            end
          end else if (count == '0) begin
            load_out        = 1'b1;
            out_status_next = ST_EMPTY;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out            = 1'b1;
          out_status_next     = ST_EXEC;
          out_id_next         = data_rdata.id;
          out_prio_next       = data_rdata.prio;
          out_runs_next       = runs_inc;
          out_created_next    = data_rdata.created;
          out_last_next       = run_done;
          data_we             = 1'b1;
          data_wdata.ran_at   = now_r;
          data_wdata.runs     = runs_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_waddr] <= data_wdata;
    data_rdata <= data_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_rdata <= next_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      nonempty <= '0;
    end else begin
      state <= state_next;
      if (add_ok) begin
        count             <= count + CW'(1);
        tail[in_prio]     <= IW'(count);
        nonempty[in_prio] <= 1'b1;
        if (!nonempty[in_prio]) head[in_prio] <= IW'(count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_start) begin
      cur_prio <= first_prio;
      cur_addr <= head[first_prio];
      now_r    <= task_in.now_time;
    end else if (emit_fire && !run_done) begin
      if (at_tail) begin
        cur_prio <= next_prio;
        cur_addr <= head[next_prio];
      end else begin
        cur_addr <= next_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (task_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status  <= out_status_next;
      out_id      <= out_id_next;
      out_prio    <= out_prio_next;
      out_runs    <= out_runs_next;
      out_created <= out_created_next;
      out_last    <= out_last_next;
    end
  end

  assign task_out.valid        = out_valid;
  assign task_out.status       = out_status;
  assign task_out.task_id      = out_id;
  assign task_out.out_priority = out_prio;
  assign task_out.runs_done    = out_runs;
  assign task_out.created_time = out_created;
  assign task_out.last_of_run  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_priority <= PRIO_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_PRIO)) begin
      max_priority <= pwdata[3:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_PRIO) ? {28'd0, max_priority} : 32'd0;

endmodule

`default_nettype wire

/* hdl/ptt_checker.sv */
// Port-level checks for the priority task table, bound to the top level.
// Depends on ptt_pkg and priority_task_table.
`default_nettype none

module ptt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_runs,
  input logic        out_last,
  input logic        pready
);
  import ptt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_EXEC |-> out_last)
    else $error("non-run result without last_of_run");

  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken in the middle of a run");

  a_runs_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_EXEC |-> out_runs != 32'd0)
    else $error("executed task with zero run count");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind priority_task_table ptt_checker u_ptt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (task_in.ready),
  .out_valid  (task_out.valid),
  .out_ready  (task_out.ready),
  .out_status (task_out.status),
  .out_runs   (task_out.runs_done),
  .out_last   (task_out.last_of_run),
  .pready     (pready)
);

`default_nettype wire
